// ----- hdl/bfdh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants of the FNV double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int NH_W       = 5;
    localparam int FB_W       = 17;
    localparam int REM_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int MOD_STEPS  = HASH_W / 2;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [NH_W-1:0] NH_RESET = 5'd1;
    localparam logic [FB_W-1:0] FB_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 2'd1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH0,
        ST_HASH1,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACCESS,
        ST_CHECK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ----- hdl/bfdh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfdh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bfdh_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_mod
// Iterative remainder unit: 32-bit dividend modulo 17-bit divisor,
// two restoring steps per cycle, one request at a time.
// ----------------------------------------------------------------------------
module bfdh_mod (
    input  logic               clk,
    input  logic               rst_n,
    input  bfdh_pkg::mod_req_t req,
    output bfdh_pkg::mod_rsp_t rsp
);

    import bfdh_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [MOD_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [HASH_W-1:0]    dvd_reg,   dvd_next;
    logic [REM_W-1:0]     rem_reg,   rem_next;
    logic [REM_W-1:0]     div_reg,   div_next;

    logic [REM_W:0]   t1;
    logic [REM_W:0]   t2;
    logic [REM_W-1:0] r1;
    logic [REM_W-1:0] r2;

    always_comb
    begin
        t1 = {rem_reg, dvd_reg[HASH_W-1]};
        r1 = (t1 >= {1'b0, div_reg}) ? REM_W'(t1 - {1'b0, div_reg}) : t1[REM_W-1:0];
        t2 = {r1, dvd_reg[HASH_W-2]};
        r2 = (t2 >= {1'b0, div_reg}) ? REM_W'(t2 - {1'b0, div_reg}) : t2[REM_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = r2;
            dvd_next = dvd_reg << 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("busy ended without done");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("start while busy");

endmodule

// ----- hdl/bloom_filter_fnv_double_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash
// Bloom filter over 32-bit keys, FNV-1a double hashing, up to k probes per request.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, key              | request in
//  out     | out_valid, out_stall, maybe_present       | result out (queries)
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
//  Insert: after idle, the key is hashed byte by byte on one shared multiplier;
//  then per probe a start state, a wait on the remainder unit, and a write.
//  Query: each probe adds a bit check, it stops at the first clear bit, and a
//  result state ends it.
//  After reset the bit store is cleared, every address in turn; in_stall is high.
//  in_stall is high during a request and while a query result waits for the output.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [bfdh_pkg::KEY_W-1:0]         key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               maybe_present,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bfdh_pkg::*;

    localparam int AW = $clog2(MAX_BITS);

    state_t            state_reg,     state_next;
    logic              cmd_reg,       cmd_next;
    logic [HASH_W-1:0] word_reg,      word_next;
    logic [HASH_W-1:0] h_reg,         h_next;
    logic [HASH_W-1:0] h0_reg,        h0_next;
    logic [HASH_W-1:0] h1_reg,        h1_next;
    logic [HASH_W-1:0] sum_reg,       sum_next;
    logic [1:0]        byte_cnt_reg,  byte_cnt_next;
    logic [NH_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic              present_reg,   present_next;
    logic              out_valid_reg, out_valid_next;
    logic              mp_reg,        mp_next;
    logic [AW-1:0]     clr_addr_reg,  clr_addr_next;
    logic [NH_W-1:0]   num_hashes_reg;
    logic [FB_W-1:0]   filter_bits_reg;

    logic [NH_W-1:0]   k_eff;
    logic [FB_W-1:0]   m_eff;
    logic [HASH_W-1:0] fnv_step;
    logic [31:0]       rem_ext;
    logic [AW-1:0]     probe_addr;
    logic              last_probe;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [0:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [0:0]        ram_rdata;

    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    assign k_eff = (7'(num_hashes_reg) > 7'(MAX_HASHES)) ? NH_W'(MAX_HASHES) : num_hashes_reg;

    always_comb
    begin
        if (filter_bits_reg == '0)
        begin
            m_eff = FB_W'(1);
        end
        else if (32'(filter_bits_reg) > 32'(MAX_BITS))
        begin
            m_eff = FB_W'(MAX_BITS);
        end
        else
        begin
            m_eff = filter_bits_reg;
        end
    end

    assign fnv_step   = (h_reg ^ {24'd0, word_reg[7:0]}) * FNV_PRIME;
    assign rem_ext    = 32'(mod_rsp.rem);
    assign probe_addr = rem_ext[AW-1:0];
    assign last_probe = (NH_W'(probe_cnt_reg + 1'b1) == k_eff);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        word_next      = word_reg;
        h_next         = h_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        sum_next       = sum_reg;
        byte_cnt_next  = byte_cnt_reg;
        probe_cnt_next = probe_cnt_reg;
        present_next   = present_reg;
        out_valid_next = out_valid_reg && out_stall;
        mp_next        = mp_reg;
        clr_addr_next  = clr_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = probe_addr;
        ram_wdata      = 1'b1;
        ram_raddr      = probe_addr;
        mod_req.start    = 1'b0;
        mod_req.dividend = (probe_cnt_reg == NH_W'(1)) ? h1_reg : sum_reg;
        mod_req.divisor  = m_eff;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 1'b0;
                if (clr_addr_reg == AW'(MAX_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    word_next     = key;
                    h_next        = '0;
                    byte_cnt_next = '0;
                    state_next    = ST_HASH0;
                end
            end
            ST_HASH0:
            begin
                h_next        = fnv_step;
                word_next     = word_reg >> 8;
                byte_cnt_next = byte_cnt_reg + 1'b1;
                if (byte_cnt_reg == 2'd3)
                begin
                    h0_next    = fnv_step;
                    word_next  = fnv_step;
                    h_next     = '0;
                    state_next = ST_HASH1;
                end
            end
            ST_HASH1:
            begin
                h_next        = fnv_step;
                word_next     = word_reg >> 8;
                byte_cnt_next = byte_cnt_reg + 1'b1;
                if (byte_cnt_reg == 2'd3)
                begin
                    h1_next        = fnv_step;
                    sum_next       = h0_reg;
                    probe_cnt_next = '0;
                    present_next   = 1'b1;
                    if (k_eff == '0)
                    begin
                        state_next = (cmd_reg == CMD_QUERY) ? ST_RESULT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                mod_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    ram_we         = 1'b1;
                    sum_next       = sum_reg + h1_reg;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = last_probe ? ST_IDLE : ST_DIV_GO;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!ram_rdata[0])
                begin
                    present_next = 1'b0;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    sum_next       = sum_reg + h1_reg;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = last_probe ? ST_RESULT : ST_DIV_GO;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    mp_next        = present_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            byte_cnt_reg  <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            out_valid_reg <= out_valid_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        word_reg    <= word_next;
        h_reg       <= h_next;
        h0_reg      <= h0_next;
        h1_reg      <= h1_next;
        sum_reg     <= sum_next;
        present_reg <= present_next;
        mp_reg      <= mp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg  <= NH_RESET;
            filter_bits_reg <= FB_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_HASHES:  num_hashes_reg  <= cfg_data[NH_W-1:0];
                CFG_FILTER_BITS: filter_bits_reg <= cfg_data[FB_W-1:0];
                default:         ;
            endcase
        end
    end

    bfdh_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    bfdh_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign maybe_present = mp_reg;
    assign cfg_ready     = 1'b1;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("remainder done outside wait state");

    a_set_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_wdata[0]) |-> (state_reg == ST_ACCESS && cmd_reg == CMD_INSERT))
        else $error("store bit set outside insert");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside result state");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_GO) |-> probe_cnt_reg < k_eff)
        else $error("probe count beyond k");

endmodule

// ----- test/bloom_filter_fnv_double_hash_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash_tb
// Self-checking bench for the FNV-1a double-hash Bloom filter. A queue of
// insert and query requests feeds a bursty driver. A scoreboard keeps its own
// copy of the bit store and register values and predicts every query answer.
// A monitor with a changing stall pattern checks the answers in order.
// Directed requests cover the register corner values first, then random
// phases run under varied probe counts and filter sizes.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash_tb;

    import bfdh_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_BITS       = 65536;
    localparam int MAX_HASHES     = 16;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_DEPTH     = 96;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] req_key;
        bit               wait_drain;
    } bloom_req_t;

    typedef struct {
        logic [KEY_W-1:0] req_key;
        logic             present;
    } bloom_answer_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  cmd           = CMD_INSERT;
    logic [KEY_W-1:0]      key           = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  maybe_present;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_NUM_HASHES;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    bit                    filter_mem [0:MAX_BITS-1];
    logic [NH_W-1:0]       probes_cfg = NH_RESET;
    logic [FB_W-1:0]       bits_cfg   = FB_RESET;

    bloom_req_t            pending_reqs[$];
    bloom_answer_t         expected_answers[$];
    logic [KEY_W-1:0]      key_pool[$];

    int                    error_count   = 0;
    int                    insert_count  = 0;
    int                    query_count   = 0;
    int                    present_count = 0;
    int                    absent_count  = 0;
    int                    reg_writes    = 0;
    int                    settings_used = 0;
    int                    quiet_cycles  = 0;
    int                    burst_left    = 8;
    int                    gap_left      = 0;
    int                    stall_span    = 0;
    stall_mode_t           stall_mode    = STALL_NONE;

    bloom_filter_fnv_double_hash #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .key           (key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .maybe_present (maybe_present),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [HASH_W-1:0] fnv1a32(input logic [HASH_W-1:0] w);
        logic [HASH_W-1:0] h;
        int                b;
        h = '0;
        for (b = 0; b < 4; b++)
        begin
            h = h ^ {24'd0, w[8*b +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // Sets the probed bits on insert; on query returns whether all are set.
    function automatic logic lookup_or_set(input logic op, input logic [KEY_W-1:0] k_in);
        logic [HASH_W-1:0] h0;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h;
        logic [31:0]       modulus;
        logic [31:0]       pos;
        logic [31:0]       idx;
        int                probes;
        int                i;
        logic              found;
        h0      = fnv1a32(k_in);
        h1      = fnv1a32(h0);
        probes  = (probes_cfg > MAX_HASHES) ? MAX_HASHES : int'(probes_cfg);
        if (bits_cfg == '0)
            modulus = 32'd1;
        else if (bits_cfg > MAX_BITS)
            modulus = MAX_BITS;
        else
            modulus = {15'd0, bits_cfg};
        found = 1'b1;
        for (i = 0; i < probes; i++)
        begin
            idx = i;
            if (i == 0)
                h = h0;
            else if (i == 1)
                h = h1;
            else
                h = h0 + idx * h1;
            pos = h % modulus;
            if (op == CMD_QUERY)
            begin
                if (!filter_mem[pos])
                begin
                    found = 1'b0;
                    break;
                end
            end
            else
                filter_mem[pos] = 1'b1;
        end
        return found;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    function automatic void add_req(input logic op, input logic [KEY_W-1:0] k_in,
                                    input bit wait_drain);
        bloom_req_t r;
        r.op         = op;
        r.req_key    = k_in;
        r.wait_drain = wait_drain;
        pending_reqs.push_back(r);
        if (op == CMD_INSERT)
        begin
            key_pool.push_back(k_in);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endfunction

    // Queries hit previously inserted keys about half the time.
    function automatic void add_random_reqs(input int count, input int insert_pct);
        logic             op;
        logic [KEY_W-1:0] k_in;
        int               n;
        for (n = 0; n < count; n++)
        begin
            op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_QUERY;
            if (key_pool.size() != 0 &&
                $urandom_range(0, 99) < ((op == CMD_INSERT) ? 15 : 55))
                k_in = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k_in = $urandom();
            add_req(op, k_in, $urandom_range(0, 99) == 0);
        end
    endfunction

    task automatic settle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NUM_HASHES:  probes_cfg = data[NH_W-1:0];
            CFG_FILTER_BITS: bits_cfg   = data[FB_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] nh_data,
                                  input logic [CFG_DATA_W-1:0] fb_data,
                                  input bit spare);
        settle();
        write_reg(CFG_NUM_HASHES, nh_data);
        if (spare)
            write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
        write_reg(CFG_FILTER_BITS, fb_data);
        if (spare)
            write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Request driver
    always @(posedge clk)
    begin : driver
        bloom_req_t    nxt;
        bloom_answer_t a;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                a.req_key = key;
                a.present = lookup_or_set(cmd, key);
                if (cmd == CMD_QUERY)
                begin
                    expected_answers.push_back(a);
                    query_count++;
                end
                else
                    insert_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].wait_drain && expected_answers.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    nxt = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= nxt.op;
                    key      <= nxt.req_key;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Result monitor and output stall pattern
    always @(posedge clk)
    begin : monitor
        bloom_answer_t a;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                    report_error($sformatf("result %0b with no query outstanding", maybe_present));
                else
                begin
                    a = expected_answers.pop_front();
                    if (maybe_present !== a.present)
                        report_error($sformatf("key %h: maybe_present expected %0b, got %0b",
                                               a.req_key, a.present, maybe_present));
                    else if (a.present)
                        present_count++;
                    else
                        absent_count++;
                end
            end
            if (stall_span == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_span = $urandom_range(16, 160);
            end
            else
                stall_span--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 1) == 1);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int p;
        int nh;
        int fb;
        int count;
        int ins_pct;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: one probe, full store
        add_req(CMD_QUERY,  32'h0000_0000, 1'b0);
        add_req(CMD_INSERT, 32'h0000_0000, 1'b0);
        add_req(CMD_QUERY,  32'h0000_0000, 1'b0);
        add_req(CMD_INSERT, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_QUERY,  32'hFFFF_FFFF, 1'b0);
        add_req(CMD_QUERY,  32'h8000_0000, 1'b0);
        add_req(CMD_QUERY,  32'h0000_0001, 1'b1);

        // probe field 31 clamps to 16, zero bit count acts as one bit
        apply_settings(17'h1FFFF, 17'd0, 1'b1);
        add_req(CMD_QUERY,  32'hDEAD_BEEF, 1'b0);
        add_req(CMD_INSERT, 32'hA5A5_A5A5, 1'b0);
        add_req(CMD_QUERY,  32'h5A5A_5A5A, 1'b0);

        // no probes; oversized bit count clamps
        apply_settings(17'h1FFE0, 17'h1FFFF, 1'b0);
        add_req(CMD_INSERT, 32'h0000_0001, 1'b0);
        add_req(CMD_QUERY,  32'h1357_9BDF, 1'b0);

        apply_settings(17'd16, 17'd65536, 1'b0);
        add_req(CMD_INSERT, 32'hCAFE_F00D, 1'b0);
        add_req(CMD_QUERY,  32'hCAFE_F00D, 1'b0);
        add_req(CMD_QUERY,  32'hCAFE_F00C, 1'b0);

        apply_settings(17'd17, 17'd65535, 1'b1);
        add_req(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
        add_req(CMD_QUERY,  32'h7FFF_FFFF, 1'b0);
        add_req(CMD_QUERY,  32'hFFFF_FFFE, 1'b0);

        apply_settings(17'd2, 17'd1, 1'b0);
        add_req(CMD_INSERT, 32'h5555_5555, 1'b0);
        add_req(CMD_QUERY,  32'hAAAA_AAAA, 1'b0);

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    nh = $urandom_range(1, 3);    fb = $urandom_range(64, 512);
                    count = 320;                  ins_pct = 45;
                end
                1:
                begin
                    nh = 1;                       fb = MAX_BITS;
                    count = 320;                  ins_pct = 50;
                end
                2:
                begin
                    nh = $urandom_range(2, 6);    fb = $urandom_range(1, 4096);
                    count = 320;                  ins_pct = 40;
                end
                3:
                begin
                    nh = MAX_HASHES;              fb = $urandom_range(65537, 131071);
                    count = 150;                  ins_pct = 50;
                end
                4:
                begin
                    nh = $urandom_range(0, 131071); fb = $urandom_range(0, 131071);
                    count = 370;                  ins_pct = 45;
                end
                default:
                begin
                    nh = $urandom_range(1, 4);    fb = $urandom_range(2, 40);
                    count = 320;                  ins_pct = 35;
                end
            endcase
            apply_settings(CFG_DATA_W'(nh), CFG_DATA_W'(fb), $urandom_range(0, 1) == 1);
            add_random_reqs(count, ins_pct);
        end

        settle();
        $display("Covered %0d inserts and %0d queries under %0d register settings, %0d writes.",
                 insert_count, query_count, settings_used, reg_writes);
        $display("Answers checked: %0d maybe present, %0d absent; %0d errors.",
                 present_count, absent_count, error_count);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bfdh_pkg.sv
hdl/bfdh_ram.sv
hdl/bfdh_mod.sv
hdl/bloom_filter_fnv_double_hash.sv
test/bloom_filter_fnv_double_hash_tb.sv
